@@ design/acl_pkg.sv @@
// ----------------------------------------------------------------------------
// acl_pkg: shared types and constants for the ARP cache lookup/update block
// Payload structs, entry layout, status and register codes, reset values.
// ----------------------------------------------------------------------------
package acl_pkg;

    // Cache geometry and register port
    localparam int ENTRIES_DFLT = 128;
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 64;
    localparam int SLOT_W       = 7;

    // Register reset values
    localparam logic [31:0] OWN_IP_RST      = 32'h0000_0000;
    localparam logic [5:0]  SUBNET_BITS_RST = 6'd24;
    localparam logic [39:0] MAX_AGE_RST     = 40'(60 * 60 * 1000);

    localparam logic [31:0] IP_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [47:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_BCAST   = 3'd1,
        ST_MISS    = 3'd2,
        ST_STALE   = 3'd3,
        ST_WRITTEN = 3'd4
    } t_acl_status;

    // Register indexes (byte address / 8)
    typedef enum logic [1:0] {
        REG_OWN_IP      = 2'd0,
        REG_SUBNET_BITS = 2'd1,
        REG_MAX_AGE     = 2'd2
    } t_acl_reg;

    // Input item
    typedef struct packed {
        logic        op;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [47:0] now_time;
    } t_acl_req;

    // Result item
    typedef struct packed {
        t_acl_status status;
        logic [47:0] mac_out;
        logic [6:0]  slot;
        logic        off_subnet;
    } t_acl_rsp;

    // One cache entry as stored in the RAM
    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [47:0] stamp;
    } t_acl_entry;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [31:0] own_ip;
        logic [5:0]  subnet_bits;
        logic [39:0] max_age;
    } t_acl_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // latch the accepted item
        logic clr;    // clear the entry at the sweep address
        logic rd;     // read the entry at the scan address
        logic fin;    // form the result, write back on update
    } t_acl_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic bcast;  // item at the input is a broadcast lookup
    } t_acl_sts;

endpackage

@@ design/acl_ram.sv @@
// ----------------------------------------------------------------------------
// acl_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module acl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/acl_regs.sv @@
// ----------------------------------------------------------------------------
// acl_regs: configuration registers on an APB-style port
// own_ip at 0x00, subnet_bits at 0x08, max_age at 0x10; 64-bit data.
// ----------------------------------------------------------------------------
module acl_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [acl_pkg::PADDR_W-1:0]  paddr,
    input  logic [acl_pkg::PDATA_W-1:0]  pwdata,
    output logic [acl_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output acl_pkg::t_acl_cfg            o_cfg
);

    logic [31:0]       r_own_ip;
    logic [5:0]        r_subnet_bits;
    logic [39:0]       r_max_age;
    logic              wr_xfer;
    acl_pkg::t_acl_reg reg_idx;

    assign pready  = 1'b1;
    assign wr_xfer = psel & penable & pwrite & pready;
    assign reg_idx = acl_pkg::t_acl_reg'(paddr[4:3]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip      <= acl_pkg::OWN_IP_RST;
            r_subnet_bits <= acl_pkg::SUBNET_BITS_RST;
            r_max_age     <= acl_pkg::MAX_AGE_RST;
        end else if (wr_xfer) begin
            case (reg_idx)
                acl_pkg::REG_OWN_IP:      r_own_ip      <= pwdata[31:0];
                acl_pkg::REG_SUBNET_BITS: r_subnet_bits <= pwdata[5:0];
                acl_pkg::REG_MAX_AGE:     r_max_age     <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            acl_pkg::REG_OWN_IP:      prdata = {32'd0, r_own_ip};
            acl_pkg::REG_SUBNET_BITS: prdata = {58'd0, r_subnet_bits};
            acl_pkg::REG_MAX_AGE:     prdata = {24'd0, r_max_age};
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg.own_ip      = r_own_ip;
    assign o_cfg.subnet_bits = r_subnet_bits;
    assign o_cfg.max_age     = r_max_age;

endmodule

@@ design/acl_ctrl.sv @@
// ----------------------------------------------------------------------------
// acl_ctrl: sequencer for the ARP cache
// Clears the table after reset, then runs one full table scan per item; a broadcast lookup skips the scan.
// ----------------------------------------------------------------------------
module acl_ctrl #(
    parameter int ENTRIES = acl_pkg::ENTRIES_DFLT,
    localparam int AW = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  acl_pkg::t_acl_sts i_sts,
    output acl_pkg::t_acl_ctl o_ctl,
    output logic [AW-1:0]     o_addr
);

    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_addr;
    logic          accept;

    assign accept = (r_state == S_IDLE) & start;

    // State and sweep/scan address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    r_addr <= '0;
                    if (start) begin
                        r_state <= i_sts.bcast ? S_FINISH : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN:  r_state <= S_FINISH;
                S_FINISH: r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // Command decode
    assign o_ctl.load = accept;
    assign o_ctl.clr  = (r_state == S_CLEAR);
    assign o_ctl.rd   = (r_state == S_SCAN);
    assign o_ctl.fin  = (r_state == S_FINISH);
    assign o_addr     = r_addr;
    assign busy       = (r_state != S_IDLE);

endmodule

@@ design/acl_dp.sv @@
// ----------------------------------------------------------------------------
// acl_dp: datapath of the ARP cache
// Table RAM, subnet/broadcast test, scan trackers and result register.
// ----------------------------------------------------------------------------
module acl_dp #(
    parameter int ENTRIES = acl_pkg::ENTRIES_DFLT,
    localparam int AW = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  acl_pkg::t_acl_req i_cmd,
    input  acl_pkg::t_acl_cfg i_cfg,
    input  acl_pkg::t_acl_ctl i_ctl,
    input  logic [AW-1:0]     i_addr,
    output acl_pkg::t_acl_sts o_sts,
    output acl_pkg::t_acl_rsp o_res,
    output logic              o_res_valid
);

    localparam int EW = $bits(acl_pkg::t_acl_entry);

    // Latched item and lookup flags
    acl_pkg::t_acl_req r_req;
    logic              r_bcast;
    logic              r_off;

    // Read pipeline
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    acl_pkg::t_acl_entry rd_ent;

    // Lookup tracker: lowest matching entry
    logic              r_found;
    logic [AW-1:0]     r_hit_idx;
    logic [47:0]       r_hit_mac;
    logic [47:0]       r_hit_stamp;

    // Update trackers: highest match, highest free, oldest
    logic              r_uhit;
    logic [AW-1:0]     r_uhit_idx;
    logic              r_free;
    logic [AW-1:0]     r_free_idx;
    logic [47:0]       r_old_stamp;
    logic [AW-1:0]     r_old_idx;

    acl_pkg::t_acl_rsp r_res;
    logic              r_res_vld;

    logic [5:0]        pfx_len;
    logic [31:0]       mask;
    logic              off_in;
    logic              bcast_in;
    logic              match;
    logic              older;
    logic [AW-1:0]     target;
    logic [47:0]       age;
    logic              stale;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    acl_pkg::t_acl_entry wr_ent;
    logic [EW-1:0]     rd_word;

    // Subnet mask and broadcast test on the incoming item
    always_comb begin
        pfx_len  = (i_cfg.subnet_bits > 6'd32) ? 6'd32 : i_cfg.subnet_bits;
        mask     = ~(acl_pkg::IP_ALL_ONES >> pfx_len);
        off_in   = ((i_cmd.ip_addr ^ i_cfg.own_ip) & mask) != 32'd0;
        bcast_in = (i_cmd.op == acl_pkg::OP_LOOKUP) &&
                   ((i_cmd.ip_addr == acl_pkg::IP_ALL_ONES) ||
                    (!off_in && (mask != acl_pkg::IP_ALL_ONES) &&
                     ((i_cmd.ip_addr & ~mask) == ~mask)));
    end

    assign o_sts.bcast = bcast_in;

    // Entry compare on the registered read data
    assign rd_ent = acl_pkg::t_acl_entry'(rd_word);
    assign match  = rd_ent.valid && (rd_ent.ip == r_req.ip_addr);
    // Smaller stamp wins; on a tie slot 0 holds, else the higher slot wins
    assign older  = (rd_ent.stamp < r_old_stamp) ||
                    ((rd_ent.stamp == r_old_stamp) && (r_old_idx != '0));

    // Update target choice
    always_comb begin
        if (r_uhit) begin
            target = r_uhit_idx;
        end else if (r_free) begin
            target = r_free_idx;
        end else begin
            target = r_old_idx;
        end
    end

    // Age of the found entry; time running backwards counts as zero
    always_comb begin
        age   = (r_req.now_time >= r_hit_stamp) ? (r_req.now_time - r_hit_stamp) : 48'd0;
        stale = age > {8'd0, i_cfg.max_age};
    end

    // RAM write: clearing sweep or update write-back
    always_comb begin
        wr_en        = i_ctl.clr | (i_ctl.fin & (r_req.op == acl_pkg::OP_UPDATE));
        wr_addr      = i_ctl.clr ? i_addr : target;
        wr_ent.valid = ~i_ctl.clr;
        wr_ent.ip    = i_ctl.clr ? 32'd0 : r_req.ip_addr;
        wr_ent.mac   = i_ctl.clr ? 48'd0 : r_req.mac_addr;
        wr_ent.stamp = i_ctl.clr ? 48'd0 : r_req.now_time;
    end

    acl_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_ent),
        .i_rd_en   (i_ctl.rd),
        .i_rd_addr (i_addr),
        .o_rd_data (rd_word)
    );

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_ctl.rd;
            r_res_vld <= i_ctl.fin;
        end
    end

    // Item latch and scan trackers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_addr;
        if (i_ctl.load) begin
            r_req   <= i_cmd;
            r_bcast <= bcast_in;
            r_off   <= off_in;
            r_found <= 1'b0;
            r_uhit  <= 1'b0;
            r_free  <= 1'b0;
        end else if (r_rd_vld) begin
            if (match && !r_found) begin
                r_found     <= 1'b1;
                r_hit_idx   <= r_rd_idx;
                r_hit_mac   <= rd_ent.mac;
                r_hit_stamp <= rd_ent.stamp;
            end
            if (match) begin
                r_uhit     <= 1'b1;
                r_uhit_idx <= r_rd_idx;
            end
            if (!rd_ent.valid) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if ((r_rd_idx == '0) || older) begin
                r_old_stamp <= rd_ent.stamp;
                r_old_idx   <= r_rd_idx;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.fin) begin
            if (r_req.op == acl_pkg::OP_UPDATE) begin
                r_res.status     <= acl_pkg::ST_WRITTEN;
                r_res.mac_out    <= r_req.mac_addr;
                r_res.slot       <= acl_pkg::SLOT_W'(target);
                r_res.off_subnet <= 1'b0;
            end else if (r_bcast) begin
                r_res.status     <= acl_pkg::ST_BCAST;
                r_res.mac_out    <= acl_pkg::MAC_ALL_ONES;
                r_res.slot       <= '0;
                r_res.off_subnet <= r_off;
            end else if (r_found) begin
                r_res.status     <= stale ? acl_pkg::ST_STALE : acl_pkg::ST_HIT;
                r_res.mac_out    <= r_hit_mac;
                r_res.slot       <= acl_pkg::SLOT_W'(r_hit_idx);
                r_res.off_subnet <= r_off;
            end else begin
                r_res.status     <= acl_pkg::ST_MISS;
                r_res.mac_out    <= '0;
                r_res.slot       <= '0;
                r_res.off_subnet <= r_off;
            end
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_vld;

endmodule

@@ design/arp_cache_lookup_update.sv @@
// ----------------------------------------------------------------------------
// arp_cache_lookup_update: IPv4-to-MAC cache with aging
// Lookup and update of a table of ENTRIES entries held in one RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Lookups and updates
// both walk the whole table through the RAM read port, one entry per cycle,
// then pass a drain and a finish state before the registered result; a
// broadcast lookup skips the walk and goes straight to the finish state.
// The result appears on o_res for exactly one cycle with o_res_valid high
// and cannot be held off, so the receiver must take it then. busy is
// already low in that cycle, so the next item may be started right away.
// After reset the block sweeps the RAM to clear every entry, holding busy
// high during the sweep; register writes are taken at any time.
// ----------------------------------------------------------------------------
module arp_cache_lookup_update #(
    parameter int ENTRIES = acl_pkg::ENTRIES_DFLT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Item channel
    input  logic                         start,
    output logic                         busy,
    input  acl_pkg::t_acl_req            i_cmd,
    output logic                         o_res_valid,
    output acl_pkg::t_acl_rsp            o_res,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [acl_pkg::PADDR_W-1:0]  paddr,
    input  logic [acl_pkg::PDATA_W-1:0]  pwdata,
    output logic [acl_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int AW = $clog2(ENTRIES);

    acl_pkg::t_acl_cfg cfg;
    acl_pkg::t_acl_ctl ctl;
    acl_pkg::t_acl_sts sts;
    logic [AW-1:0]     addr;

    acl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    acl_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_addr  (addr)
    );

    acl_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_cfg       (cfg),
        .i_ctl       (ctl),
        .i_addr      (addr),
        .o_sts       (sts),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );

endmodule

@@ design/acl_chk.sv @@
// ----------------------------------------------------------------------------
// acl_chk: port-level checks for the ARP cache
// Result strobe timing against busy, and fixed fields of fixed results.
// ----------------------------------------------------------------------------
module acl_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              o_res_valid,
    input  acl_pkg::t_acl_rsp o_res
);

    // A transfer makes the block busy in the next cycle
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after an item transfer");

    // A result is a single-cycle pulse
    a_res_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    // The block is ready again while its result is shown
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("busy while result shown");

    // Broadcast answers carry the broadcast MAC and slot zero
    a_bcast_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status == acl_pkg::ST_BCAST) |->
            (o_res.mac_out == acl_pkg::MAC_ALL_ONES) && (o_res.slot == '0))
        else $error("broadcast result fields wrong");

    // Misses carry a zero MAC and slot zero
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status == acl_pkg::ST_MISS) |->
            (o_res.mac_out == '0) && (o_res.slot == '0))
        else $error("miss result fields wrong");

endmodule

bind arp_cache_lookup_update acl_chk u_acl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
